// ===== rtl/core/skt_pkg.sv =====
// types and constants shared by the sorted key table cells and top level
package skt_pkg;

    localparam int KEY_W   = 31;
    localparam int PLD_W   = 32;
    localparam int COUNT_W = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef struct packed {
        logic               command;
        logic [KEY_W-1:0]   key;
        logic [PLD_W-1:0]   payload;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [PLD_W-1:0]   found_payload;
        logic [COUNT_W-1:0] entry_count;
    } t_out;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic               insert_en;
        logic [KEY_W-1:0]   key;
        logic [PLD_W-1:0]   payload;
    } t_ctrl;

    // what one cell hands to the next one down the chain
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [PLD_W-1:0]   payload;
        logic               at_or_past;
        logic               acc_hit;
        logic [PLD_W-1:0]   acc_payload;
    } t_link;

endpackage

// ===== rtl/core/sorted_key_table_insert_search.sv =====
// Sorted key table of DEPTH entries built as a chain of cells, each holding one key and
// payload in ascending order. On an insert every cell compares the broadcast key and
// either keeps its entry, loads the new one or takes its upstream neighbour's, and the
// result beat is ready the next cycle. In a search the first-match payload ripples down
// the cell chain one cell per cycle and is read at the tail. Only one item is in work at
// a time; a new beat is taken only when the block is idle and the output register is
// empty or being read in that same cycle. An insert into a full table is refused with
// status full and changes nothing.
module sorted_key_table_insert_search #(
    parameter int DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  skt_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output skt_pkg::t_out o_data
);
    import skt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_step;
    logic [KEY_W-1:0] r_skey;
    logic            r_out_valid;
    t_out            r_out;

    t_ctrl           ctrl;
    t_link           w_link [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic            out_free;
    logic            in_accept;
    logic            full;
    logic            search_done;
    logic            out_load;

    assign out_free    = !r_out_valid || i_ready;
    assign o_ready     = (r_state == S_IDLE) && out_free;
    assign in_accept   = i_valid && o_ready;
    assign full        = (r_count == CW'(DEPTH));
    assign search_done = (r_state == S_SEARCH) && (r_step == CW'(DEPTH)) && out_free;
    assign out_load    = (in_accept && (i_data.command == CMD_INSERT)) || search_done;

    assign ctrl.insert_en = in_accept && (i_data.command == CMD_INSERT) && !full;
    assign ctrl.key       = (r_state == S_SEARCH) ? r_skey : i_data.key;
    assign ctrl.payload   = i_data.payload;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                skt_cell #(.IS_HEAD(1'b1)) u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_ctrl (ctrl),
                    .i_prev ('0),
                    .o_link (w_link[gi])
                );
            end else begin : g_body
                skt_cell #(.IS_HEAD(1'b0)) u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_ctrl (ctrl),
                    .i_prev (w_link[gi-1]),
                    .o_link (w_link[gi])
                );
            end
            assign w_valid[gi] = w_link[gi].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_data.command == CMD_INSERT) begin
                            r_out.found_payload <= '0;
                            if (full) begin
                                r_out.status      <= ST_FULL;
                                r_out.entry_count <= COUNT_W'(r_count);
                            end else begin
                                r_out.status      <= ST_INSERTED;
                                r_out.entry_count <= COUNT_W'(r_count + CW'(1));
                                r_count           <= r_count + CW'(1);
                            end
                        end else begin
                            r_skey  <= i_data.key;
                            r_step  <= '0;
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // wait for the hit wave to reach the tail cell
                    if (r_step != CW'(DEPTH)) begin
                        r_step <= r_step + CW'(1);
                    end
                    if (search_done) begin
                        r_out.status        <= w_link[DEPTH-1].acc_hit ? ST_FOUND : ST_MISSING;
                        r_out.found_payload <= w_link[DEPTH-1].acc_payload;
                        r_out.entry_count   <= COUNT_W'(r_count);
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_valid_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("occupied cells disagree with entry count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.insert_en |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not add one entry");

    a_search_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |=> r_count == $past(r_count))
        else $error("entry count changed during search");
`endif

endmodule

// ===== rtl/core/skt_cell.sv =====
// one entry of the sorted table: holds a key and payload, shifts on insert, passes search hits on
module skt_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  skt_pkg::t_ctrl i_ctrl,
    input  skt_pkg::t_link i_prev,
    output skt_pkg::t_link o_link
);
    import skt_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [PLD_W-1:0] r_payload;
    logic             r_acc_hit;
    logic [PLD_W-1:0] r_acc_payload;

    logic at_or_past;
    logic match;

    // head moves only for a strictly smaller key, later cells for any key not above theirs
    always_comb begin
        if (IS_HEAD) begin
            at_or_past = !r_valid || (i_ctrl.key < r_key);
        end else begin
            at_or_past = !r_valid || !(r_key < i_ctrl.key);
        end
        match = r_valid && (r_key == i_ctrl.key);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.insert_en) begin
            if (i_prev.at_or_past) begin
                r_valid <= i_prev.valid;
            end else if (at_or_past) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert_en) begin
            if (i_prev.at_or_past) begin
                r_key     <= i_prev.key;
                r_payload <= i_prev.payload;
            end else if (at_or_past) begin
                r_key     <= i_ctrl.key;
                r_payload <= i_ctrl.payload;
            end
        end
        // an earlier hit has priority over this cell's own match
        if (i_prev.acc_hit) begin
            r_acc_hit     <= 1'b1;
            r_acc_payload <= i_prev.acc_payload;
        end else begin
            r_acc_hit     <= match;
            r_acc_payload <= match ? r_payload : '0;
        end
    end

    assign o_link.valid       = r_valid;
    assign o_link.key         = r_key;
    assign o_link.payload     = r_payload;
    assign o_link.at_or_past  = at_or_past;
    assign o_link.acc_hit     = r_acc_hit;
    assign o_link.acc_payload = r_acc_payload;

endmodule

// ===== sim/tb_sorted_key_table_insert_search.sv =====
// self-checking testbench for the sorted key table: shadow table, queued beats, random handshakes
module tb_sorted_key_table_insert_search;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int DEPTH      = 64;
    localparam int N_RANDOM   = 550;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 300;
    localparam int HOLD_AFTER = 250;
    localparam int QUIET_TAIL = 60;

    typedef struct {
        t_in beat;
        bit  wait_drained;
    } t_queued_op;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_beat  = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_beat;

    logic in_taken = 1'b0;

    // shadow copy of the table
    logic [KEY_W-1:0] shadow_key [DEPTH];
    logic [PLD_W-1:0] shadow_pld [DEPTH];
    int               shadow_used = 0;

    t_queued_op       queued_ops[$];
    t_out             due_replies[$];
    logic [KEY_W-1:0] used_keys[$];

    int  errors        = 0;
    int  replies_seen  = 0;
    int  cycle_count   = 0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;

    sorted_key_table_insert_search #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_beat),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_beat)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic t_out apply_to_shadow_table(t_in op);
        t_out r;
        int   pos;
        r.status        = ST_MISSING;
        r.found_payload = '0;
        if (op.command == CMD_INSERT) begin
            if (shadow_used >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // a key equal to the head stays behind the head
                if (shadow_used == 0 || op.key < shadow_key[0]) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < shadow_used && shadow_key[pos] < op.key)
                        pos++;
                end
                for (int i = shadow_used; i > pos; i--) begin
                    shadow_key[i] = shadow_key[i-1];
                    shadow_pld[i] = shadow_pld[i-1];
                end
                shadow_key[pos] = op.key;
                shadow_pld[pos] = op.payload;
                shadow_used++;
                r.status = ST_INSERTED;
            end
        end else begin
            for (int i = 0; i < shadow_used; i++) begin
                if (shadow_key[i] == op.key) begin
                    r.status        = ST_FOUND;
                    r.found_payload = shadow_pld[i];
                    break;
                end
            end
        end
        r.entry_count = COUNT_W'(shadow_used);
        return r;
    endfunction

    task automatic flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR: %s", msg);
    endtask

    task automatic push_op(logic cmd, logic [KEY_W-1:0] key, logic [PLD_W-1:0] pld,
                           bit wait_drained);
        t_queued_op q;
        q.beat.command = cmd;
        q.beat.key     = key;
        q.beat.payload = pld;
        q.wait_drained = wait_drained;
        queued_ops.push_back(q);
        if (cmd == CMD_INSERT)
            used_keys.push_back(key);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return KEY_W'($urandom_range(0, 40));
        if (sel < 5 && used_keys.size() != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (sel == 5)
            return $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
        return KEY_W'($urandom());
    endfunction

    function automatic logic [PLD_W-1:0] pick_payload();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // monitor: checks result beats and predicts on accepted input beats
    always @(posedge clk) begin : watch_beats
        t_out want;
        in_taken <= in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                replies_seen++;
                if (due_replies.size() == 0) begin
                    flag_error($sformatf("unexpected result beat status %0d payload %h count %0d",
                                         out_beat.status, out_beat.found_payload,
                                         out_beat.entry_count));
                end else begin
                    want = due_replies.pop_front();
                    if (out_beat.status !== want.status ||
                        out_beat.found_payload !== want.found_payload ||
                        out_beat.entry_count !== want.entry_count)
                        flag_error($sformatf(
                            "result %0d: expected status %0d payload %h count %0d, got %0d %h %0d",
                            replies_seen, want.status, want.found_payload, want.entry_count,
                            out_beat.status, out_beat.found_payload, out_beat.entry_count));
                end
            end
            if (in_valid && in_ready)
                due_replies.push_back(apply_to_shadow_table(in_beat));
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("sorted_key_table_insert_search test failed");
            $finish;
        end
    end

    // driver: presents queued beats with random gaps
    always @(negedge clk) begin : drive_input
        logic       offer;
        logic       no_idle;
        t_queued_op nxt;
        no_idle = queued_ops.size() < QUIET_TAIL || (cycle_count % 1200) >= 800;
        offer   = 1'b0;
        if (rst_n && !(in_valid && !in_taken)) begin
            if (in_taken && !no_idle && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 9);
            if (send_gap > 0) begin
                send_gap--;
            end else if (queued_ops.size() != 0 &&
                         !(queued_ops[0].wait_drained && due_replies.size() != 0)) begin
                nxt     = queued_ops.pop_front();
                offer   = 1'b1;
                in_beat <= nxt.beat;
            end
            in_valid <= offer;
        end
    end

    // receiver: random stalls plus one long hold so the block backs up
    always @(negedge clk) begin : drive_ready
        logic no_idle;
        no_idle = queued_ops.size() < QUIET_TAIL || (cycle_count % 1200) >= 800;
        if (!hold_done && replies_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin : run_test
        logic [KEY_W-1:0] kmax;
        logic             cmd;
        kmax = {KEY_W{1'b1}};

        // searches on an empty table
        push_op(CMD_SEARCH, '0, '0, 1'b0);
        push_op(CMD_SEARCH, kmax, '1, 1'b0);
        // first insert, then one below the head
        push_op(CMD_INSERT, KEY_W'(100), '1, 1'b0);
        push_op(CMD_INSERT, KEY_W'(50), '0, 1'b0);
        // equal to head: goes behind it, head still answers
        push_op(CMD_INSERT, KEY_W'(50), PLD_W'(32'h5a5a_a5a5), 1'b0);
        push_op(CMD_SEARCH, KEY_W'(50), '1, 1'b0);
        // duplicate behind the head: newest answers
        push_op(CMD_INSERT, KEY_W'(200), PLD_W'(32'h1234_5678), 1'b0);
        push_op(CMD_INSERT, KEY_W'(200), PLD_W'(32'h8765_4321), 1'b0);
        push_op(CMD_SEARCH, KEY_W'(200), '0, 1'b0);
        push_op(CMD_INSERT, '0, PLD_W'(32'hdead_beef), 1'b0);
        push_op(CMD_INSERT, kmax, PLD_W'(32'hcafe_f00d), 1'b0);
        push_op(CMD_SEARCH, '0, '0, 1'b0);
        push_op(CMD_SEARCH, kmax, '0, 1'b0);
        push_op(CMD_SEARCH, KEY_W'(150), '0, 1'b0);
        push_op(CMD_SEARCH, KEY_W'(201), '1, 1'b0);
        push_op(CMD_INSERT, kmax, PLD_W'(32'h0f0f_f0f0), 1'b0);
        push_op(CMD_SEARCH, kmax, '0, 1'b0);
        push_op(CMD_INSERT, '0, PLD_W'(32'hffff_0000), 1'b0);
        push_op(CMD_SEARCH, '0, '0, 1'b0);
        push_op(CMD_SEARCH, KEY_W'(100), '1, 1'b0);

        // random part; first beat waits until the table has answered everything
        for (int n = 0; n < N_RANDOM; n++) begin
            cmd = ($urandom_range(0, 99) < 35) ? CMD_INSERT : CMD_SEARCH;
            if (cmd == CMD_SEARCH && used_keys.size() != 0 && $urandom_range(0, 1))
                push_op(cmd, used_keys[$urandom_range(0, used_keys.size() - 1)],
                        pick_payload(), n == 0);
            else
                push_op(cmd, pick_key(), pick_payload(), n == 0);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (queued_ops.size() != 0 || in_valid)
            @(posedge clk);
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (due_replies.size() != 0)
            flag_error("results still outstanding at end of run");
        if (errors == 0)
            $display("sorted_key_table_insert_search test passed");
        else
            $display("sorted_key_table_insert_search test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/sorted_key_table_insert_search.sv
sim/tb_sorted_key_table_insert_search.sv
